// File: hw/rtl/bm25sa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bm25sa_pkg;

   typedef struct packed {
      logic        mode;
      logic [9:0]  row;
      logic [23:0] tf_count;
      logic [23:0] doc_tokens;
      logic [23:0] idf;
      logic [15:0] boost;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] score;
      logic        found;
      logic        batch_end;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_READ = 2'd1,
      OP_DROP = 2'd2,
      OP_NULL = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [9:0]  row;
      logic [23:0] tf_count;
      logic [23:0] doc_tokens;
      logic [23:0] idf;
      logic [15:0] boost;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic [15:0] k1_gain;
      logic [16:0] length_weight;
      logic [27:0] avg_doc_tokens;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] score;
   } ram_word_type;

   localparam logic       MODE_ADD = 1'b0;

   localparam logic [1:0] REG_K1_GAIN        = 2'd0;
   localparam logic [1:0] REG_LENGTH_WEIGHT  = 2'd1;
   localparam logic [1:0] REG_AVG_DOC_TOKENS = 2'd2;

   localparam logic [15:0] K1_RESET  = 16'd4915;
   localparam logic [16:0] B_RESET   = 17'd49152;
   localparam logic [27:0] AVG_RESET = 28'd256;
   localparam logic [16:0] B_ONE     = 17'd65536;
   localparam logic [16:0] K1_ONE    = 17'd4096;
   localparam logic [31:0] SCORE_MAX = 32'hFFFF_FFFF;
   localparam logic [40:0] RATIO_CAP = 41'd1 << 40;

   localparam int DVD_W = 48;
   localparam int DVS_W = 47;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV1_STEPS = 6'd48;
   localparam logic [CNT_W-1:0] DIV2_STEPS = 6'd21;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic [DVS_W-1:0] rem_init;
      logic [DVD_W-1:0] num_init;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/bm25sa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bm25sa_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/bm25sa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_front
   import bm25sa_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   input  wire logic    queue_full,
   input  wire logic    clearing,
   output logic         queue_push,
   output cmd_type      queue_cmd
);
   logic in_range;

   // hold off items until the score store is swept clean
   assign req_full   = queue_full || clearing;
   assign queue_push = req_push && !req_full;
   assign in_range   = (32'(req_data.row) < 32'(ROWS));

   always_comb begin
      queue_cmd.row        = req_data.row;
      queue_cmd.tf_count   = req_data.tf_count;
      queue_cmd.doc_tokens = req_data.doc_tokens;
      queue_cmd.idf        = req_data.idf;
      queue_cmd.boost      = req_data.boost;
      queue_cmd.last       = req_data.last;
      if (req_data.mode == MODE_ADD) begin
         queue_cmd.op = in_range ? OP_ADD : OP_DROP;
      end else begin
         queue_cmd.op = in_range ? OP_READ : OP_NULL;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/bm25sa_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_div
   import bm25sa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);
   logic [DVS_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [DVD_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   // one quotient bit per cycle, restoring
   assign rem_sh = {rem_ff, num_ff[DVD_W-1]};
   assign ge     = (rem_sh >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in = ge ? DVS_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DVS_W-1:0];
         num_in = {num_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         rem_in  = div_req.rem_init;
         div_in  = div_req.divisor;
         num_in  = div_req.num_init;
         quo_in  = '0;
         cnt_in  = div_req.count;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bm25sa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_back
   import bm25sa_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    queue_empty,
   input  wire cmd_type queue_cmd,
   output logic         queue_pop,
   input  wire logic    out_full,
   output logic         out_push,
   output rsp_type      out_rsp,
   output logic         clearing
);
   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_DECODE = 14'b00000000000100,
      S_DIV1   = 14'b00000000001000,
      S_NORM   = 14'b00000000010000,
      S_NORM2  = 14'b00000000100000,
      S_WGT    = 14'b00000001000000,
      S_DEN    = 14'b00000010000000,
      S_DIV2GO = 14'b00000100000000,
      S_DIV2   = 14'b00001000000000,
      S_BASE   = 14'b00010000000000,
      S_SCALE  = 14'b00100000000000,
      S_ACC    = 14'b01000000000000,
      S_RDWAIT = 14'b10000000000000
   } state_type;

   state_type    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   cmd_type      cmd_ff, cmd_in;
   logic [40:0]  ratio_ff, ratio_in;
   logic [57:0]  prod_ff, prod_in;
   logic [41:0]  norm_ff, norm_in;
   logic [45:0]  weight_ff, weight_in;
   logic [46:0]  denom_ff, denom_in;
   logic [40:0]  numer_ff, numer_in;
   logic [20:0]  part_ff, part_in;
   logic [28:0]  base_ff, base_in;
   logic [31:0]  add_ff, add_in;

   logic [57:0]  wgt_prod;
   logic [16:0]  k1_plus;
   logic [40:0]  numer_prod;
   logic [44:0]  base_prod;
   logic [44:0]  scale_prod;
   logic [31:0]  old_score;
   logic [32:0]  sum;

   div_req_type  div_req;
   div_rsp_type  div_rsp;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   ram_word_type  ram_wr_data, ram_rd_data;

   bm25sa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bm25sa_ram #(
      .WIDTH ($bits(ram_word_type)),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign wgt_prod   = cfg.k1_gain * norm_ff;
   assign k1_plus    = 17'(cfg.k1_gain) + K1_ONE;
   assign numer_prod = cmd_ff.tf_count * k1_plus;
   assign base_prod  = cmd_ff.idf * part_ff;
   assign scale_prod = base_ff * cmd_ff.boost;
   assign old_score  = ram_rd_data.valid ? ram_rd_data.score : '0;
   assign sum        = {1'b0, old_score} + {1'b0, add_ff};
   assign clearing   = (state_ff == S_CLEAR);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      ratio_in  = ratio_ff;
      prod_in   = prod_ff;
      norm_in   = norm_ff;
      weight_in = weight_ff;
      denom_in  = denom_ff;
      numer_in  = numer_ff;
      part_in   = part_ff;
      base_in   = base_ff;
      add_in    = add_ff;

      queue_pop         = 1'b0;
      out_push          = 1'b0;
      out_rsp.score     = '0;
      out_rsp.found     = 1'b0;
      out_rsp.batch_end = cmd_ff.last;

      div_req.start    = 1'b0;
      div_req.count    = DIV1_STEPS;
      div_req.rem_init = '0;
      div_req.num_init = {cmd_ff.doc_tokens, 24'd0};
      div_req.divisor  = DVS_W'(cfg.avg_doc_tokens);

      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(cmd_ff.row);
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(cmd_ff.row);

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               cmd_in    = queue_cmd;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (cmd_ff.op)
               OP_ADD: begin
                  if (cfg.avg_doc_tokens == '0) begin
                     weight_in = '0;
                     state_in  = S_DEN;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV1;
                  end
               end
               OP_READ: begin
                  ram_rd_en = 1'b1;
                  state_in  = S_RDWAIT;
               end
               OP_NULL: begin
                  if (!out_full) begin
                     out_push = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_DROP: begin
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               ratio_in = (div_rsp.quotient > DVD_W'(RATIO_CAP)) ? RATIO_CAP
                                                                : div_rsp.quotient[40:0];
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            prod_in  = cfg.length_weight * ratio_ff;
            state_in = S_NORM2;
         end
         S_NORM2: begin
            norm_in  = 42'(B_ONE - cfg.length_weight) + prod_ff[57:16];
            state_in = S_WGT;
         end
         S_WGT: begin
            weight_in = wgt_prod[57:12];
            state_in  = S_DEN;
         end
         S_DEN: begin
            denom_in = {7'd0, cmd_ff.tf_count, 16'd0} + {1'b0, weight_ff};
            numer_in = numer_prod;
            state_in = S_DIV2GO;
         end
         S_DIV2GO: begin
            // zero denominator only when tf and weight are both zero
            if (denom_ff == '0) begin
               part_in  = '0;
               state_in = S_BASE;
            end else begin
               div_req.start    = 1'b1;
               div_req.count    = DIV2_STEPS;
               div_req.rem_init = DVS_W'(numer_ff >> 1);
               div_req.num_init = {numer_ff[0], 47'd0};
               div_req.divisor  = denom_ff;
               state_in         = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               part_in  = div_rsp.quotient[20:0];
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            base_in   = base_prod[44:16];
            ram_rd_en = 1'b1;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            add_in   = (scale_prod[44:40] != '0) ? SCORE_MAX : scale_prod[39:8];
            state_in = S_ACC;
         end
         S_ACC: begin
            ram_wr_en         = 1'b1;
            ram_wr_data.valid = 1'b1;
            ram_wr_data.score = sum[32] ? SCORE_MAX : sum[31:0];
            state_in          = S_IDLE;
         end
         S_RDWAIT: begin
            if (!out_full) begin
               out_push      = 1'b1;
               out_rsp.score = old_score;
               out_rsp.found = ram_rd_data.valid;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      ratio_ff  <= ratio_in;
      prod_ff   <= prod_in;
      norm_ff   <= norm_in;
      weight_ff <= weight_in;
      denom_ff  <= denom_in;
      numer_ff  <= numer_in;
      part_ff   <= part_in;
      base_ff   <= base_in;
      add_ff    <= add_in;
   end
endmodule
`default_nettype wire

// File: hw/rtl/bm25_score_accumulator.sv
// BM25 score accumulator: per-row relevance scores in a store of ROWS entries.
// Request side is a queue: drive req_data and req_push; an item is taken on a
// clock edge with req_push high and req_full low. mode 0 adds the boosted BM25
// term score into the row (saturating at all ones); mode 1 reads the row.
// Result side is a queue: each read item yields one result on rsp_data while
// rsp_empty is low, taken on an edge with rsp_pop high. Adds yield no result.
// csr_wen/csr_index/csr_wdata write k1, b and average document length; write
// them only while no item is in flight.
// An add runs a 48-step length-ratio division and a 21-step score division
// on one shared radix-2 divider, with decode, multiplies and the
// read-modify-write of the store around them; the length division is skipped
// when the average length is zero. A read pops in idle, reads the store in
// decode and pushes its result once the result queue has room. One item is
// worked at a time; two-entry queues on both sides let neighbors keep moving.
// After reset a clearing pass marks every row empty; req_full stays high
// during it. A stalled receiver fills the result queue, which stalls the
// back end and then, through the request queue, req_full.
`timescale 1ns / 1ps
`default_nettype none
module bm25_score_accumulator
   import bm25sa_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   output logic             rsp_empty,
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [27:0] csr_wdata
);
   cfg_type cfg_ff, cfg_in;
   logic    cq_full, cq_empty, cq_push, cq_pop, clearing;
   cmd_type cq_in_cmd, cq_out_cmd;
   logic    rq_full, rq_push;
   rsp_type rq_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_K1_GAIN: cfg_in.k1_gain = csr_wdata[15:0];
            // clamp b to one
            REG_LENGTH_WEIGHT: cfg_in.length_weight =
               (csr_wdata[16:0] > B_ONE) ? B_ONE : csr_wdata[16:0];
            REG_AVG_DOC_TOKENS: cfg_in.avg_doc_tokens = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k1_gain        <= K1_RESET;
         cfg_ff.length_weight  <= B_RESET;
         cfg_ff.avg_doc_tokens <= AVG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bm25sa_front #(
      .ROWS (ROWS)
   ) u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .queue_full (cq_full),
      .clearing   (clearing),
      .queue_push (cq_push),
      .queue_cmd  (cq_in_cmd)
   );

   bm25sa_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_in_cmd),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_data  (cq_out_cmd),
      .empty     (cq_empty)
   );

   bm25sa_back #(
      .ROWS (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (cq_empty),
      .queue_cmd   (cq_out_cmd),
      .queue_pop   (cq_pop),
      .out_full    (rq_full),
      .out_push    (rq_push),
      .out_rsp     (rq_in),
      .clearing    (clearing)
   );

   bm25sa_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );
endmodule
`default_nettype wire

// File: hw/rtl/bm25sa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bm25sa_checker
   import bm25sa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);
   // store sweep follows every reset
   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("request side open right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting right after reset");

   a_null_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.found) |-> (rsp_data.score == '0))
      else $error("null result carries a score");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting result changed");
endmodule

bind bm25_score_accumulator bm25sa_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire
